FILE: rtl/core/cma_pkg.sv
package cma_pkg;

  localparam int SAMPLE_W            = 16;
  localparam int HW_W                = 4;
  localparam int DIV_W               = HW_W + 1;
  // 31 samples of 16 bits: magnitude needs 20 bits, plus sign
  localparam int MAG_W               = 20;
  localparam int SUM_W               = MAG_W + 1;
  localparam int MAX_HALF_WINDOW_DEF = 15;
  localparam int JOB_FIFO_DEPTH      = 2;
  localparam int OUT_FIFO_DEPTH      = 16;

  // one request's worth of work, as classified by the front end
  typedef struct packed {
    logic            do_avg;
    logic            do_raw;
    logic [HW_W-1:0] n;
    logic [HW_W-1:0] tail;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                last_out;
  } result_t;

endpackage

FILE: rtl/core/centered_moving_average_top.sv
// Centred moving average over a record of signed 16-bit samples. Each input
// request carries one sample and a flag on the record's last sample; for every
// index the block gives the truncating mean of the 2n+1 samples centred there
// (n = half_window, clamped to MAX_HALF_WINDOW), with the first n and last n
// samples passed through raw. Results lag the input by n samples, and the last
// input flushes the tail, marking the final result with out_last_out; the
// record state then clears, half_window is kept. Write cfg_half_window only
// while the block is idle. One request is worked at a time: the window sum is
// accumulated over the single read port of the delay line, one sample a cycle,
// then a bit-serial restoring divider forms the 20-bit quotient. Results wait
// in a 16-deep output queue, so a stalled consumer only holds the block once
// that queue fills.
module centered_moving_average_top import cma_pkg::*; #(
  parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last_in,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [SAMPLE_W-1:0] out_filtered,
  output logic                out_last_out,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [HW_W-1:0]     cfg_half_window
);

  localparam int IDX_W = $clog2(2 * MAX_HALF_WINDOW + 1);
  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(result_t);

  job_t                job_in;
  job_t                job_head;
  logic [JOB_W-1:0]    job_head_bits;
  logic                job_push;
  logic                job_pop;
  logic                job_full;
  logic                job_empty;
  logic                back_idle;
  logic                accept_en;
  logic [IDX_W-1:0]    rd_idx;
  logic [SAMPLE_W-1:0] rd_data;
  logic                res_push;
  logic                res_full;
  result_t             res;
  logic [RES_W-1:0]    out_bits;
  result_t             out_res;

  // the delay line is shared with the back end, so the front end takes the
  // next request only once the previous one is fully worked
  assign accept_en = job_empty && back_idle;

  cma_front #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .IDX_W           (IDX_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_sample       (in_sample),
    .in_last_in      (in_last_in),
    .in_full         (in_full),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_half_window (cfg_half_window),
    .accept_en       (accept_en),
    .job_push        (job_push),
    .job             (job_in),
    .rd_idx          (rd_idx),
    .rd_data         (rd_data)
  );

  cma_fifo #(
    .DEPTH   (JOB_FIFO_DEPTH),
    .WIDTH   (JOB_W)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_in),
    .pop     (job_pop),
    .rd_data (job_head_bits),
    .full    (job_full),
    .empty   (job_empty)
  );

  // job_full cannot assert: at most one job is ever in flight
  assign job_head = job_t'(job_head_bits);

  cma_back #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .IDX_W           (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .idle      (back_idle),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  cma_fifo #(
    .DEPTH   (OUT_FIFO_DEPTH),
    .WIDTH   (RES_W)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .pop     (out_pop),
    .rd_data (out_bits),
    .full    (res_full),
    .empty   (out_empty)
  );

  assign out_res      = result_t'(out_bits);
  assign out_filtered = out_res.filtered;
  assign out_last_out = out_res.last_out && !job_full;

endmodule

FILE: rtl/core/cma_fifo.sv
module cma_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  // DEPTH must be a power of two: pointers wrap naturally
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/cma_front.sv
module cma_front import cma_pkg::*; #(
  parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
  parameter int IDX_W           = $clog2(2 * MAX_HALF_WINDOW + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_last_in,
  output logic                in_full,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [HW_W-1:0]     cfg_half_window,
  input  logic                accept_en,
  output logic                job_push,
  output job_t                job,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [SAMPLE_W-1:0] rd_data
);

  localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CMP_W  = 8;

  logic [SAMPLE_W-1:0] dl_r [DEPTH];
  logic [HW_W-1:0]     hw_r;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic [HW_W-1:0]     n_cl;
  logic [CMP_W-1:0]    fill_c;
  logic [CMP_W-1:0]    n_c;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign in_full   = !accept_en;
  assign accept    = in_push && accept_en;
  assign rd_data   = dl_r[rd_idx];

  assign fill_nxt = (fill_r == FILL_W'(DEPTH)) ? fill_r : fill_r + 1'b1;
  assign n_cl     = (CMP_W'(hw_r) > CMP_W'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : hw_r;
  assign fill_c   = CMP_W'(fill_nxt);
  assign n_c      = CMP_W'(n_cl);

  always_comb begin
    job.n      = n_cl;
    job.last   = in_last_in;
    job.do_avg = (fill_c >= CMP_W'({n_cl, 1'b1}));
    job.do_raw = !job.do_avg && (fill_c >= n_c + CMP_W'(1));
    if (!in_last_in) begin
      job.tail = '0;
    end else if (fill_c < n_c) begin
      job.tail = HW_W'(fill_nxt);
    end else begin
      job.tail = n_cl;
    end
  end

  // a request that yields nothing needs no trip through the back end
  assign job_push = accept && (job.do_avg || job.do_raw || in_last_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r   <= '0;
      fill_r <= '0;
    end else begin
      if (cfg_valid) begin
        hw_r <= cfg_half_window;
      end
      if (accept) begin
        fill_r <= in_last_in ? '0 : fill_nxt;
      end
    end
  end

  // entries beyond the fill count are never read, so no clearing
  always_ff @(posedge clk) begin
    if (accept) begin
      dl_r[0] <= in_sample;
      for (int i = 1; i < DEPTH; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

endmodule

FILE: rtl/core/cma_back.sv
module cma_back import cma_pkg::*; #(
  parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
  parameter int IDX_W           = $clog2(2 * MAX_HALF_WINDOW + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  job_t                job_head,
  output logic                job_pop,
  output logic                idle,
  output logic [IDX_W-1:0]    rd_idx,
  input  logic [SAMPLE_W-1:0] rd_data,
  input  logic                res_full,
  output logic                res_push,
  output result_t             res
);

  localparam int BIT_W = $clog2(MAG_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_EMIT,
    ST_TAIL
  } state_t;

  state_t                state_r;
  job_t                  job_r;
  logic [IDX_W-1:0]      cnt_r;
  logic signed [SUM_W-1:0] acc_r;
  logic [MAG_W-1:0]      quo_r;
  logic [DIV_W-1:0]      rem_r;
  logic [BIT_W-1:0]      bit_r;
  logic                  neg_r;
  logic [SAMPLE_W-1:0]   res_r;
  logic [HW_W-1:0]       tail_r;

  logic [DIV_W-1:0]      divisor;
  logic [DIV_W:0]        shifted;
  logic [DIV_W:0]        trial;
  logic                  ge;
  logic [DIV_W-1:0]      rem_nxt;
  logic signed [SUM_W-1:0] acc_nxt;
  logic [SUM_W-1:0]      acc_abs;
  logic [MAG_W-1:0]      quo_signed;

  assign divisor = {job_r.n, 1'b1};
  assign shifted = {rem_r, quo_r[MAG_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign ge      = (shifted >= {1'b0, divisor});
  assign rem_nxt = ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];

  assign acc_nxt    = acc_r + {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
  assign acc_abs    = acc_r[SUM_W-1] ? (~acc_r + 1'b1) : acc_r;
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  assign idle     = (state_r == ST_IDLE);
  assign job_pop  = idle && !job_empty;
  assign res_push = !res_full && ((state_r == ST_EMIT) || (state_r == ST_TAIL));

  always_comb begin
    if (state_r == ST_TAIL) begin
      res.filtered = rd_data;
      res.last_out = job_r.last && (tail_r == HW_W'(1));
    end else begin
      res.filtered = res_r;
      res.last_out = job_r.last && (tail_r == '0);
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: rd_idx = IDX_W'(job_head.n);
      ST_SUM:  rd_idx = cnt_r;
      ST_TAIL: rd_idx = IDX_W'(tail_r - 1'b1);
      default: rd_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!job_empty) begin
            job_r  <= job_head;
            tail_r <= job_head.tail;
            acc_r  <= '0;
            cnt_r  <= '0;
            res_r  <= rd_data;
            if (job_head.do_avg) begin
              state_r <= ST_SUM;
            end else if (job_head.do_raw) begin
              state_r <= ST_EMIT;
            end else begin
              state_r <= ST_TAIL;
            end
          end
        end
        ST_SUM: begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDX_W'({job_r.n, 1'b0})) begin
            state_r <= ST_ABS;
          end
        end
        ST_ABS: begin
          quo_r   <= acc_abs[MAG_W-1:0];
          neg_r   <= acc_r[SUM_W-1];
          rem_r   <= '0;
          bit_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          quo_r <= {quo_r[MAG_W-2:0], ge};
          rem_r <= rem_nxt;
          bit_r <= bit_r + 1'b1;
          if (bit_r == BIT_W'(MAG_W - 1)) begin
            state_r <= ST_FIX;
          end
        end
        ST_FIX: begin
          res_r   <= quo_signed[SAMPLE_W-1:0];
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_full) begin
            state_r <= (tail_r != '0) ? ST_TAIL : ST_IDLE;
          end
        end
        ST_TAIL: begin
          if (!res_full) begin
            tail_r <= tail_r - 1'b1;
            if (tail_r == HW_W'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
